[hw/rtl/lkvc_pkg.sv]
// Shared widths, constants and codes for the least-recently-used key-value cache.
package lkvc_pkg;

  localparam int unsigned ENTRIES_DEFAULT = 16;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned CAP_W           = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
  localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};
  localparam logic [DATA_W-1:0] PUT_VALUE  = '0;

  typedef enum logic {
    KIND_GET = 1'b0,
    KIND_PUT = 1'b1
  } kind_e;

endpackage

[hw/rtl/lkvc_lookup.sv]
// Parallel key match, eviction victim and free slot selection for the cache.
module lkvc_lookup import lkvc_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
  input  logic signed [DATA_W-1:0]           key_i,
  input  logic        [ENTRIES-1:0]          valid_i,
  input  logic signed [DATA_W-1:0]           keys_i [ENTRIES],
  input  logic        [$clog2(ENTRIES)-1:0]  ranks_i [ENTRIES],
  input  logic        [$clog2(ENTRIES+1)-1:0] held_i,
  input  logic        [CAP_W-1:0]            cap_i,
  output logic                               hit_o,
  output logic        [$clog2(ENTRIES)-1:0]  hit_idx_o,
  output logic        [$clog2(ENTRIES)-1:0]  hit_rank_o,
  output logic                               evict_o,
  output logic        [ENTRIES-1:0]          victim_o,
  output logic        [$clog2(ENTRIES)-1:0]  slot_idx_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CMP_W-1:0]   cap_ext;
  logic [CMP_W-1:0]   eff_cap;
  logic [CNT_W-1:0]   oldest_rank;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] free_vec;

  always_comb begin
    cap_ext = CMP_W'(cap_i);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    evict_o = CMP_W'(held_i) >= eff_cap;
  end

  // Ranks of the valid entries form a permutation of 0 to held minus one,
  // so the least recent entry is the one whose rank equals held minus one.
  assign oldest_rank = held_i - CNT_W'(1);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]    = valid_i[i] && (keys_i[i] == key_i);
      victim_o[i] = evict_o && valid_i[i] && (CNT_W'(ranks_i[i]) == oldest_rank);
      free_vec[i] = !valid_i[i] || victim_o[i];
    end
  end

  always_comb begin
    hit_o      = |match;
    hit_idx_o  = '0;
    slot_idx_o = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx_o = IDX_W'(i);
      end
      if (free_vec[i]) begin
        slot_idx_o = IDX_W'(i);
      end
    end
    hit_rank_o = ranks_i[hit_idx_o];
  end

endmodule

[hw/rtl/lru_key_value_cache.sv]
// Top level of the fully associative key-value cache with least-recently-used replacement.
//
//   Channel   Handshake                 Beat contents
//   --------  ------------------------  --------------------------------
//   request   in_valid_i / in_stall_o   kind_i, key_i, value_i
//   response  out_valid_o / out_stall_i found_o, read_value_o
//   config    cfg_valid_i / cfg_ready_o cfg_data_i (capacity)
//
// A request beat is held in an input register; once the output register can take a
// response, the key is matched against all entries, the store and the recency ranks
// are updated and the response is loaded into an output register, so one request per
// cycle is sustained while the response channel is not stalled, as the match and rank
// update are combinational. Reset empties the store and sets the capacity to sixteen.
// A stalled response holds the output register and, once the input register is
// occupied, stalls the request channel.
module lru_key_value_cache import lkvc_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     kind_i,
  input  logic signed [DATA_W-1:0] key_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     found_o,
  output logic signed [DATA_W-1:0] read_value_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic        [CAP_W-1:0]  cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  logic                     in_valid_q;
  kind_e                    kind_q;
  logic signed [DATA_W-1:0] key_q;
  logic signed [DATA_W-1:0] value_q;

  logic                     out_valid_q;
  logic                     found_q;
  logic signed [DATA_W-1:0] read_value_q;

  logic [CAP_W-1:0]         cap_q;
  logic [CNT_W-1:0]         held_q;
  logic [CNT_W-1:0]         held_d;
  logic [ENTRIES-1:0]       valid_q;
  logic [ENTRIES-1:0]       valid_d;
  logic [IDX_W-1:0]         rank_q [ENTRIES];
  logic [IDX_W-1:0]         rank_d [ENTRIES];
  logic signed [DATA_W-1:0] keys_q [ENTRIES];
  logic signed [DATA_W-1:0] values_q [ENTRIES];

  logic                     hit;
  logic [IDX_W-1:0]         hit_idx;
  logic [IDX_W-1:0]         hit_rank;
  logic                     evict;
  logic [ENTRIES-1:0]       victim;
  logic [IDX_W-1:0]         slot_idx;

  logic                     in_accept;
  logic                     process;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_idx;
  logic                     found_d;
  logic signed [DATA_W-1:0] read_value_d;

  assign process     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !process;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign read_value_o = read_value_q;

  lkvc_lookup #(
    .ENTRIES (ENTRIES)
  ) u_lookup (
    .key_i      (key_q),
    .valid_i    (valid_q),
    .keys_i     (keys_q),
    .ranks_i    (rank_q),
    .held_i     (held_q),
    .cap_i      (cap_q),
    .hit_o      (hit),
    .hit_idx_o  (hit_idx),
    .hit_rank_o (hit_rank),
    .evict_o    (evict),
    .victim_o   (victim),
    .slot_idx_o (slot_idx)
  );

  always_comb begin
    valid_d      = valid_q;
    rank_d       = rank_q;
    held_d       = held_q;
    wr_en        = 1'b0;
    wr_idx       = hit_idx;
    found_d      = hit;
    read_value_d = MISS_VALUE;
    if (hit) begin
      // A hit moves the entry to the front; entries ahead of it move back by one.
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i] && (IDX_W'(i) != hit_idx) && (rank_q[i] < hit_rank)) begin
          rank_d[i] = rank_q[i] + IDX_W'(1);
        end
      end
      rank_d[hit_idx] = '0;
      read_value_d    = values_q[hit_idx];
      wr_en           = (kind_q == KIND_PUT);
    end else if (kind_q == KIND_PUT) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (victim[i]) begin
          valid_d[i] = 1'b0;
        end else if (valid_q[i]) begin
          rank_d[i] = rank_q[i] + IDX_W'(1);
        end
      end
      valid_d[slot_idx] = 1'b1;
      rank_d[slot_idx]  = '0;
      wr_en             = 1'b1;
      wr_idx            = slot_idx;
      if (!evict) begin
        held_d = held_q + CNT_W'(1);
      end
    end
    if (kind_q == KIND_PUT) begin
      read_value_d = PUT_VALUE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cap_q       <= CAP_RESET;
      held_q      <= '0;
      valid_q     <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (process) begin
        in_valid_q <= 1'b0;
      end
      if (process) begin
        out_valid_q <= 1'b1;
        held_q      <= held_d;
        valid_q     <= valid_d;
        rank_q      <= rank_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q  <= kind_e'(kind_i);
      key_q   <= key_i;
      value_q <= value_i;
    end
    if (process) begin
      found_q      <= found_d;
      read_value_q <= read_value_d;
      if (wr_en) begin
        keys_q[wr_idx]   <= key_q;
        values_q[wr_idx] <= value_q;
      end
    end
  end

endmodule

[dv/lru_key_value_cache_tb.sv]
// Self-checking testbench for the least-recently-used key-value cache.
module testbench;
  import lkvc_pkg::*;

  localparam int unsigned SLOTS       = ENTRIES_DEFAULT;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_OPS   = 117;
  localparam int unsigned POOL_MAX    = 24;

  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] value;
  } reply_t;

  typedef struct {
    bit                set_cap;
    logic [CAP_W-1:0]  cap;
    kind_e             kind;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] val;
    bit                typed;
    reply_t            want;
  } step_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              kind_i       = 1'b0;
  logic [DATA_W-1:0] key_i        = '0;
  logic [DATA_W-1:0] value_i      = '0;
  logic              out_stall_i  = 1'b0;
  logic              cfg_valid_i  = 1'b0;
  logic [CAP_W-1:0]  cfg_data_i   = '0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic              found_o;
  logic [DATA_W-1:0] read_value_o;
  logic              cfg_ready_o;

  lru_key_value_cache u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .found_o      (found_o),
    .read_value_o (read_value_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // Shadow copy of the store.
  logic [DATA_W-1:0] slot_key [SLOTS];
  logic [DATA_W-1:0] slot_val [SLOTS];
  bit                slot_used [SLOTS];
  int unsigned       slot_age [SLOTS];
  int unsigned       n_held      = 0;
  logic [CAP_W-1:0]  cap_setting = CAP_RESET;

  reply_t      pending_replies [$];
  int unsigned mismatches    = 0;
  int unsigned beats_checked = 0;
  int unsigned gets_hit      = 0;
  int unsigned gets_missed   = 0;
  int unsigned puts_done     = 0;
  int unsigned evictions     = 0;
  int unsigned cap_writes    = 0;
  int unsigned burst_left    = 30;
  int unsigned cycle_count   = 0;

  step_t plan [26] = '{
    '{1'b0, '0, KIND_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, MISS_VALUE}},
    '{1'b0, '0, KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{1'b0, PUT_VALUE}},
    '{1'b0, '0, KIND_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'h7FFF_FFFF}},
    '{1'b0, '0, KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{1'b0, PUT_VALUE}},
    '{1'b0, '0, KIND_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{1'b1, 32'h8000_0000}},
    '{1'b0, '0, KIND_PUT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b1, PUT_VALUE}},
    '{1'b0, '0, KIND_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF}},
    '{1'b0, '0, KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, MISS_VALUE}},
    '{1'b0, '0, KIND_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, PUT_VALUE}},
    '{1'b0, '0, KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000}},
    '{1'b0, '0, KIND_PUT, 32'h0000_0000, 32'h5555_5555, 1'b1, '{1'b0, PUT_VALUE}},
    '{1'b0, '0, KIND_PUT, 32'h0000_0001, 32'hAAAA_AAAA, 1'b1, '{1'b0, PUT_VALUE}},
    '{1'b0, '0, KIND_GET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h5555_5555}},
    '{1'b0, '0, KIND_GET, 32'h0000_0001, 32'h0000_0000, 1'b1, '{1'b1, 32'hAAAA_AAAA}},
    '{1'b0, '0, KIND_PUT, 32'h0000_0001, 32'h1234_5678, 1'b1, '{1'b1, PUT_VALUE}},
    '{1'b0, '0, KIND_GET, 32'h0000_0001, 32'h0000_0000, 1'b1, '{1'b1, 32'h1234_5678}},
    '{1'b1, 5'd2, KIND_GET, '0, '0, 1'b0, '{1'b0, '0}},
    '{1'b0, '0, KIND_PUT, 32'h0000_0002, 32'h0000_0002, 1'b1, '{1'b0, PUT_VALUE}},
    '{1'b0, '0, KIND_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, MISS_VALUE}},
    '{1'b0, '0, KIND_PUT, 32'h0000_0003, 32'h0000_0003, 1'b0, '{1'b0, '0}},
    '{1'b0, '0, KIND_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b0, MISS_VALUE}},
    '{1'b0, '0, KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '{1'b0, '0}},
    '{1'b1, 5'd0, KIND_GET, '0, '0, 1'b0, '{1'b0, '0}},
    '{1'b0, '0, KIND_PUT, 32'h0000_0004, 32'h0000_0004, 1'b0, '{1'b0, '0}},
    '{1'b0, '0, KIND_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, MISS_VALUE}},
    '{1'b1, 5'd31, KIND_GET, '0, '0, 1'b0, '{1'b0, '0}}
  };

  function automatic int unsigned cap_limit();
    if (cap_setting == 0) return 1;
    if (cap_setting > SLOTS) return SLOTS;
    return cap_setting;
  endfunction

  function automatic void make_newest(int unsigned s);
    for (int unsigned i = 0; i < SLOTS; i++)
      if (slot_used[i] && i != s && slot_age[i] < slot_age[s]) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  function automatic void evict_oldest_slot();
    int victim;
    victim = -1;
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
    if (victim >= 0) begin
      slot_used[victim] = 1'b0;
      slot_age[victim]  = 0;
      if (n_held > 0) n_held--;
      evictions++;
    end
  endfunction

  function automatic int first_free_slot();
    for (int i = 0; i < SLOTS; i++)
      if (!slot_used[i]) return i;
    return -1;
  endfunction

  function automatic void insert_entry(logic [DATA_W-1:0] key, logic [DATA_W-1:0] val);
    int s;
    if (n_held >= cap_limit()) evict_oldest_slot();
    s = first_free_slot();
    if (s < 0) begin
      evict_oldest_slot();
      s = first_free_slot();
    end
    for (int unsigned i = 0; i < SLOTS; i++)
      if (slot_used[i]) slot_age[i]++;
    slot_key[s]  = key;
    slot_val[s]  = val;
    slot_used[s] = 1'b1;
    slot_age[s]  = 0;
    n_held++;
  endfunction

  function automatic reply_t cache_access(kind_e kind, logic [DATA_W-1:0] key,
                                          logic [DATA_W-1:0] val);
    reply_t r;
    int     hit;
    hit = -1;
    for (int i = 0; i < SLOTS; i++)
      if (hit < 0 && slot_used[i] && slot_key[i] == key) hit = i;
    r.found = (hit >= 0);
    if (kind == KIND_GET) begin
      if (hit >= 0) begin
        make_newest(hit);
        r.value = slot_val[hit];
        gets_hit++;
      end else begin
        r.value = MISS_VALUE;
        gets_missed++;
      end
    end else begin
      if (hit >= 0) begin
        slot_val[hit] = val;
        make_newest(hit);
      end else begin
        insert_entry(key, val);
      end
      r.value = PUT_VALUE;
      puts_done++;
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(kind_e kind, logic [DATA_W-1:0] key, logic [DATA_W-1:0] val,
                      bit typed, reply_t want);
    reply_t guess;
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    key_i      <= key;
    value_i    <= val;
    do @(negedge clk_i); while (in_stall_o !== 1'b0);
    guess = cache_access(kind, key, val);
    pending_replies.insert(pending_replies.size(), typed ? want : guess);
    @(posedge clk_i);
  endtask

  task automatic pace(bit last);
    if (burst_left > 0) burst_left--;
    if (last || burst_left == 0) begin
      in_valid_i <= 1'b0;
      if (!last) repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90)
                                               : $urandom_range(1, 16);
    end
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] c);
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= c;
    do @(negedge clk_i); while (cfg_ready_o !== 1'b1);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cap_setting = c;
    cap_writes++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // The receiver opens with a long hold-off so that the request channel backs up.
  initial begin : receiver
    int unsigned span;
    int unsigned mode;
    wait (rst_ni === 1'b1);
    repeat (80) begin
      @(posedge clk_i);
      out_stall_i <= 1'b1;
    end
    forever begin
      mode = $urandom_range(0, 19);
      span = (mode == 0) ? $urandom_range(50, 90) : $urandom_range(5, 60);
      repeat (span) begin
        @(posedge clk_i);
        if (mode == 0)      out_stall_i <= 1'b1;
        else if (mode < 7)  out_stall_i <= 1'b0;
        else if (mode < 14) out_stall_i <= ($urandom_range(0, 9) < 3);
        else                out_stall_i <= ($urandom_range(0, 9) < 7);
      end
    end
  end

  always @(negedge clk_i) begin : reply_check
    reply_t head;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected reply beat: found=%0b read_value=%0d", found_o,
               $signed(read_value_o));
        mismatches++;
      end else begin
        head = pending_replies[0];
        pending_replies.delete(0);
        beats_checked++;
        if (found_o !== head.found) begin
          $error("found: expected %0b, got %0b", head.found, found_o);
          mismatches++;
        end
        if (read_value_o !== head.value) begin
          $error("read_value: expected %0d, got %0d", $signed(head.value),
                 $signed(read_value_o));
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [CAP_W-1:0]  cap_plan [12] = '{5'd1, 5'd4, 5'd0, 5'd16, 5'd2, 5'd31,
                                         5'd3, 5'd17, 5'd8, 5'd1, 5'd12, 5'd5};
    logic [DATA_W-1:0] pool [POOL_MAX];
    int unsigned       pool_n;
    logic [DATA_W-1:0] key;
    reply_t            none;
    none = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_age[i]  = 0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < $size(plan); i++) begin
      if (plan[i].set_cap) begin
        set_capacity(plan[i].cap);
      end else begin
        send(plan[i].kind, plan[i].key, plan[i].val, plan[i].typed, plan[i].want);
        pace(i == $size(plan) - 1 || plan[i + 1].set_cap);
      end
    end

    foreach (cap_plan[p]) begin
      set_capacity(cap_plan[p]);
      pool_n = cap_limit() + $urandom_range(1, 6);
      for (int unsigned j = 0; j < pool_n; j++) pool[j] = rand_word();
      for (int unsigned n = 0; n < PHASE_OPS; n++) begin
        key = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, pool_n - 1)];
        send(kind_e'($urandom_range(0, 1)), key, rand_word(), 1'b0, none);
        pace(n == PHASE_OPS - 1);
      end
    end

    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Covered %0d gets (%0d hits, %0d misses) and %0d puts with %0d evictions,",
             gets_hit + gets_missed, gets_hit, gets_missed, puts_done, evictions);
    $display("across %0d capacity writes; %0d reply beats checked, %0d mismatches.",
             cap_writes, beats_checked, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/lkvc_pkg.sv
hw/rtl/lkvc_lookup.sv
hw/rtl/lru_key_value_cache.sv
dv/lru_key_value_cache_tb.sv
